[rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define RCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rcm_pkg.sv]
package rcm_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 512;
    localparam int MAX_HEIGHT_DEFAULT = 512;

    localparam int OPCODE_W   = 3;
    localparam int COORD_W    = 16;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;
    localparam int WORD_W     = 32;
    localparam int BIT_IDX_W  = 5;

    localparam logic [CFG_W-1:0] MASK_WIDTH_RESET  = CFG_W'(512);
    localparam logic [CFG_W-1:0] MASK_HEIGHT_RESET = CFG_W'(512);

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_FILL      = 3'd2,
        OP_PROTECT   = 3'd3,
        OP_INTERSECT = 3'd4,
        OP_INVERT    = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_NOP       = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [COORD_W-1:0]  x_first;
        logic signed [COORD_W-1:0]  y_first;
        logic signed [COORD_W-1:0]  x_second;
        logic signed [COORD_W-1:0]  y_second;
        logic                       fill_value;
    } item_t;

    typedef struct packed {
        logic coord_error;
        logic permitted;
    } result_t;

endpackage

[rtl/rcm_mask_ram.sv]
module rcm_mask_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rcm_pkg::WORD_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [rcm_pkg::WORD_W-1:0] rd_data
);

    logic [rcm_pkg::WORD_W-1:0] mem [DEPTH];
    logic [rcm_pkg::WORD_W-1:0] rd_data_reg;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rcm_word_update.sv]
module rcm_word_update #(
    parameter int XW  = 10,
    parameter int YW  = 10,
    parameter int WIW = 4,
    parameter int YIW = 9
) (
    input  rcm_pkg::opcode_t           op,
    input  logic                       fill_value,
    input  logic [rcm_pkg::WORD_W-1:0] old_word,
    input  logic [WIW-1:0]             word_idx,
    input  logic [YIW-1:0]             row,
    input  logic [XW-1:0]              eff_w,
    input  logic [XW-1:0]              x_lo,
    input  logic [XW-1:0]              x_hi,
    input  logic [YW-1:0]              y_lo,
    input  logic [YW-1:0]              y_hi,
    output logic [rcm_pkg::WORD_W-1:0] new_word
);

    logic             in_y;
    logic             in_use;
    logic             in_rect;
    logic [WIW+4:0]   xpos;

    always_comb begin
        in_y     = (32'(row) >= 32'(y_lo)) && (32'(row) < 32'(y_hi));
        new_word = old_word;
        in_use   = 1'b0;
        in_rect  = 1'b0;
        xpos     = '0;
        for (int i = 0; i < rcm_pkg::WORD_W; i++) begin
            xpos    = {word_idx, rcm_pkg::BIT_IDX_W'(i)};
            in_use  = 32'(xpos) < 32'(eff_w);
            in_rect = in_y && (32'(xpos) >= 32'(x_lo)) && (32'(xpos) < 32'(x_hi));
            case (op)
                rcm_pkg::OP_FILL: begin
                    if (in_rect) new_word[i] = !fill_value;
                end
                rcm_pkg::OP_PROTECT: begin
                    if (in_use) new_word[i] = !in_rect;
                end
                rcm_pkg::OP_INTERSECT: begin
                    if (in_use && !in_rect) new_word[i] = 1'b0;
                end
                rcm_pkg::OP_INVERT: begin
                    if (in_use) new_word[i] = !old_word[i];
                end
                default: begin
                    new_word[i] = old_word[i];
                end
            endcase
        end
    end

endmodule

[rtl/rcm_engine.sv]
module rcm_engine #(
    parameter int MAX_WIDTH  = rcm_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = rcm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rcm_pkg::item_t            s_item,
    input  logic [rcm_pkg::CFG_W-1:0] mask_width,
    input  logic [rcm_pkg::CFG_W-1:0] mask_height,
    output logic                      res_valid,
    input  logic                      res_ready,
    output rcm_pkg::result_t          res
);

    localparam int ROW_WORDS = (MAX_WIDTH + 31) / 32;
    localparam int DEPTH     = ROW_WORDS * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW        = $clog2(MAX_WIDTH + 1);
    localparam int YW        = $clog2(MAX_HEIGHT + 1);
    localparam int WIW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int YIW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW        = rcm_pkg::COORD_W;
    localparam int WW        = rcm_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_PREP,
        S_SWEEP,
        S_DRAIN,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    rcm_pkg::item_t     item_reg, item_next;
    rcm_pkg::result_t   res_reg, res_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               clr_fill_reg, clr_fill_next;
    logic [XW-1:0]      x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic [YW-1:0]      y_lo_reg, y_lo_next, y_hi_reg, y_hi_next;
    logic [YIW-1:0]     row_reg, row_next;
    logic [AW-1:0]      row_base_reg, row_base_next;
    logic [WIW-1:0]     word_reg, word_next;
    logic               b_valid_reg, b_valid_next;
    logic [AW-1:0]      b_addr_reg, b_addr_next;
    logic [WIW-1:0]     b_word_reg, b_word_next;
    logic [YIW-1:0]     b_row_reg, b_row_next;
    logic [AW-1:0]      pix_addr_reg, pix_addr_next;
    logic [rcm_pkg::BIT_IDX_W-1:0] pix_bit_reg, pix_bit_next;
    logic               pix_err_reg, pix_err_next;

    logic [XW-1:0]      eff_w;
    logic [YW-1:0]      eff_h;
    logic [XW-1:0]      eff_w_m1;
    logic [WIW-1:0]     last_word;
    logic [YIW-1:0]     last_row;
    logic               pix_err_c;
    logic [AW-1:0]      pix_addr_c;
    logic [AW-1:0]      sweep_addr_c;
    logic signed [CW-1:0] x_min, x_max, y_min, y_max;
    logic               degenerate;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [WW-1:0]      mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [WW-1:0]      mem_rd_data;
    logic [WW-1:0]      upd_word;
    logic [WW-1:0]      pix_word;

    function automatic logic [XW-1:0] clamp_x(input logic signed [CW-1:0] v,
                                              input logic [XW-1:0] hi);
        logic [XW-1:0] r;
        if (v[CW-1]) r = '0;
        else if (32'(v[CW-2:0]) > 32'(hi)) r = hi;
        else r = XW'(v[CW-2:0]);
        return r;
    endfunction

    function automatic logic [YW-1:0] clamp_y(input logic signed [CW-1:0] v,
                                              input logic [YW-1:0] hi);
        logic [YW-1:0] r;
        if (v[CW-1]) r = '0;
        else if (32'(v[CW-2:0]) > 32'(hi)) r = hi;
        else r = YW'(v[CW-2:0]);
        return r;
    endfunction

    // registers above the limit act as the limit
    assign eff_w = (32'(mask_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(mask_width);
    assign eff_h = (32'(mask_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(mask_height);
    assign eff_w_m1  = eff_w - XW'(1);
    assign last_word = WIW'(eff_w_m1 >> 5);
    assign last_row  = YIW'(eff_h - YW'(1));

    assign pix_err_c = item_reg.x_first[CW-1] || item_reg.y_first[CW-1]
                    || (32'(item_reg.x_first[CW-2:0]) >= 32'(eff_w))
                    || (32'(item_reg.y_first[CW-2:0]) >= 32'(eff_h));
    assign pix_addr_c = AW'(32'(item_reg.y_first[YIW-1:0]) * ROW_WORDS
                            + 32'(item_reg.x_first[WIW+4:5]));
    assign sweep_addr_c = row_base_reg + AW'(word_reg);

    assign x_min = (item_reg.x_first > item_reg.x_second) ? item_reg.x_second
                                                          : item_reg.x_first;
    assign x_max = (item_reg.x_first > item_reg.x_second) ? item_reg.x_first
                                                          : item_reg.x_second;
    assign y_min = (item_reg.y_first > item_reg.y_second) ? item_reg.y_second
                                                          : item_reg.y_first;
    assign y_max = (item_reg.y_first > item_reg.y_second) ? item_reg.y_first
                                                          : item_reg.y_second;
    assign degenerate = (item_reg.x_first == item_reg.x_second)
                     || (item_reg.y_first == item_reg.y_second);

    always_comb begin
        pix_word = mem_rd_data;
        pix_word[pix_bit_reg] = item_reg.fill_value;
    end

    rcm_word_update #(
        .XW  (XW),
        .YW  (YW),
        .WIW (WIW),
        .YIW (YIW)
    ) u_word_update (
        .op         (item_reg.opcode),
        .fill_value (item_reg.fill_value),
        .old_word   (mem_rd_data),
        .word_idx   (b_word_reg),
        .row        (b_row_reg),
        .eff_w      (eff_w),
        .x_lo       (x_lo_reg),
        .x_hi       (x_hi_reg),
        .y_lo       (y_lo_reg),
        .y_hi       (y_hi_reg),
        .new_word   (upd_word)
    );

    rcm_mask_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mask_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // memory ports
    always_comb begin
        mem_rd_en   = ((state_reg == S_PIX_RD) && !pix_err_c) || (state_reg == S_SWEEP);
        mem_rd_addr = (state_reg == S_PIX_RD) ? pix_addr_c : sweep_addr_c;
        mem_wr_en   = 1'b0;
        mem_wr_addr = b_addr_reg;
        mem_wr_data = upd_word;
        if ((state_reg == S_INIT) || (state_reg == S_CLEAR)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = {WW{clr_fill_reg}};
        end else if (b_valid_reg) begin
            mem_wr_en = 1'b1;
        end else if ((state_reg == S_PIX_WR) && (item_reg.opcode == rcm_pkg::OP_WRITE)
                     && !pix_err_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pix_addr_reg;
            mem_wr_data = pix_word;
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        clr_addr_next = clr_addr_reg;
        clr_fill_next = clr_fill_reg;
        x_lo_next     = x_lo_reg;
        x_hi_next     = x_hi_reg;
        y_lo_next     = y_lo_reg;
        y_hi_next     = y_hi_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        word_next     = word_reg;
        b_valid_next  = 1'b0;
        b_addr_next   = b_addr_reg;
        b_word_next   = b_word_reg;
        b_row_next    = b_row_reg;
        pix_addr_next = pix_addr_reg;
        pix_bit_next  = pix_bit_reg;
        pix_err_next  = pix_err_reg;

        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    res_next  = '0;
                    unique case (s_item.opcode) inside
                        rcm_pkg::OP_READ, rcm_pkg::OP_WRITE: state_next = S_PIX_RD;
                        rcm_pkg::OP_FILL, rcm_pkg::OP_PROTECT,
                        rcm_pkg::OP_INTERSECT, rcm_pkg::OP_INVERT: state_next = S_PREP;
                        rcm_pkg::OP_CLEAR: begin
                            state_next    = S_CLEAR;
                            clr_addr_next = '0;
                            clr_fill_next = s_item.fill_value;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PIX_RD: begin
                pix_err_next  = pix_err_c;
                pix_addr_next = pix_addr_c;
                pix_bit_next  = item_reg.x_first[rcm_pkg::BIT_IDX_W-1:0];
                state_next    = S_PIX_WR;
            end
            S_PIX_WR: begin
                res_next.coord_error = pix_err_reg;
                res_next.permitted   = !pix_err_reg && (item_reg.opcode == rcm_pkg::OP_READ)
                                       && mem_rd_data[pix_bit_reg];
                state_next           = S_DONE;
            end
            S_PREP: begin
                x_lo_next     = clamp_x(x_min, eff_w);
                x_hi_next     = clamp_x(x_max, eff_w);
                y_lo_next     = clamp_y(y_min, eff_h);
                y_hi_next     = clamp_y(y_max, eff_h);
                row_next      = '0;
                row_base_next = '0;
                word_next     = '0;
                if (degenerate || (eff_w == '0) || (eff_h == '0)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP: begin
                b_valid_next = 1'b1;
                b_addr_next  = sweep_addr_c;
                b_word_next  = word_reg;
                b_row_next   = row_reg;
                if (word_reg == last_word) begin
                    word_next     = '0;
                    row_next      = row_reg + YIW'(1);
                    row_base_next = row_base_reg + AW'(ROW_WORDS);
                    if (row_reg == last_row) begin
                        state_next = S_DRAIN;
                    end
                end else begin
                    word_next = word_reg + WIW'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        x_lo_reg     <= x_lo_next;
        x_hi_reg     <= x_hi_next;
        y_lo_reg     <= y_lo_next;
        y_hi_reg     <= y_hi_next;
        row_reg      <= row_next;
        row_base_reg <= row_base_next;
        word_reg     <= word_next;
        b_addr_reg   <= b_addr_next;
        b_word_reg   <= b_word_next;
        b_row_reg    <= b_row_next;
        pix_addr_reg <= pix_addr_next;
        pix_bit_reg  <= pix_bit_next;
        pix_err_reg  <= pix_err_next;
        if (!aresetn) begin
            state_reg    <= S_INIT;
            clr_addr_reg <= '0;
            clr_fill_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_fill_reg <= clr_fill_next;
            b_valid_reg  <= b_valid_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

[rtl/raster_clip_mask_engine.sv]
// raster clip mask engine: a one-bit-per-pixel permission mask (1 permitted,
// 0 protected) of up to MAX_WIDTH x MAX_HEIGHT pixels, held as 32-bit words in
// one synchronous ram of ceil(MAX_WIDTH/32)*MAX_HEIGHT entries (8192 by default).
// each request gives exactly one result; requests are worked one at a time.
// per request: a pixel read or write steps through address, ram read, modify
// and write, and result; rectangle ops run a read-modify-write sweep that
// moves through the ram one word per cycle over the rows and words in use;
// clear all writes one word per cycle over the whole storage; opcode 7 and
// degenerate rectangles leave the ram untouched. after reset the ram is
// swept to zero with s_tready low; configuration writes are taken during
// that pass as at any time.
// a result waiting in the output register does not hold off the next request
`include "assert_macros.svh"

module raster_clip_mask_engine #(
    parameter int MAX_WIDTH  = rcm_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = rcm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcm_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
    // fill_value[64], zero fill [71:65]
    input  logic [rcm_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [rcm_pkg::OPCODE_W-1:0]      s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // permitted[0], coord_error[1], zero fill [7:2]
    output logic [rcm_pkg::M_TDATA_W-1:0]     m_tdata
);

    // configuration register indexes
    typedef enum logic [rcm_pkg::CFG_IDX_W-1:0] {
        REG_MASK_WIDTH  = 1'b0,
        REG_MASK_HEIGHT = 1'b1
    } cfg_reg_t;

    logic [rcm_pkg::CFG_W-1:0] mask_width_reg;
    logic [rcm_pkg::CFG_W-1:0] mask_height_reg;

    rcm_pkg::item_t   s_item;
    rcm_pkg::result_t eng_res;
    logic             eng_res_valid;
    logic             res_ready;
    logic             m_tvalid_reg;
    rcm_pkg::result_t m_result_reg;

    // config registers, written whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_width_reg  <= rcm_pkg::MASK_WIDTH_RESET;
            mask_height_reg <= rcm_pkg::MASK_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MASK_WIDTH:  mask_width_reg  <= cfg_data;
                REG_MASK_HEIGHT: mask_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack the request
    always_comb begin
        s_item.opcode     = rcm_pkg::opcode_t'(s_tuser);
        s_item.x_first    = s_tdata[15:0];
        s_item.y_first    = s_tdata[31:16];
        s_item.x_second   = s_tdata[47:32];
        s_item.y_second   = s_tdata[63:48];
        s_item.fill_value = s_tdata[64];
    end

    // sequencer with the mask ram behind it
    rcm_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_item      (s_item),
        .mask_width  (mask_width_reg),
        .mask_height (mask_height_reg),
        .res_valid   (eng_res_valid),
        .res_ready   (res_ready),
        .res         (eng_res)
    );

    // output register: the slot frees up in the cycle it is taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (eng_res_valid && res_ready) begin
            m_result_reg <= eng_res;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eng_res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(rcm_pkg::M_TDATA_W - 2){1'b0}},
                       m_result_reg.coord_error, m_result_reg.permitted};

    // one request in flight: ready drops right after an accept
    `RCM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "request accepted while another is in flight")

    // an idle engine holds no unsent result
    `RCM_ASSERT_IMPL(a_idle_no_result, aclk, aresetn, s_tready, !eng_res_valid,
        "engine ready while a result is pending")

    // a finished result waits while the output slot is full
    `RCM_ASSERT_NEXT(a_result_held, aclk, aresetn, eng_res_valid && !res_ready,
        eng_res_valid && $stable(eng_res), "pending result dropped or changed")

    // an out-of-range pixel never reads as permitted
    `RCM_ASSERT_IMPL(a_err_not_permitted, aclk, aresetn, m_tvalid && m_tdata[1],
        !m_tdata[0], "coord_error with permitted set")

endmodule

[bench/tb_top.sv]
module tb_top;
    import rcm_pkg::*;

    localparam int MASK_COLS = MAX_WIDTH_DEFAULT;
    localparam int MASK_ROWS = MAX_HEIGHT_DEFAULT;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 1'b1;

    // slack in cycles after the last result
    localparam int DRAIN_CYCLES = 16;
    // several times the slowest legal run, in time units (20 per cycle)
    localparam longint RUN_LIMIT = 80_000_000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [OPCODE_W-1:0]    s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // when set, neither side inserts idle cycles
    bit quiet = 1'b0;

    // mask settings of the random phases: width, height and request count.
    // most are narrow or short so that a sweep costs few cycles; zero and
    // values above the maximum are in here on purpose
    int phase_w [12] = '{16, 1, 33, 512, 7,   0, 1023, 64,   40, 512, 300, 2};
    int phase_h [12] = '{8,  1, 5,  4,   512, 0, 3,    1023, 12, 512, 2,   300};
    int phase_n [12] = '{300, 120, 250, 150, 80, 60, 150, 60, 300, 20, 150, 100};

    // own copy of the permission bitmap and the two size registers; every
    // accepted request is applied here at once and its result queued
    class mask_permit_checker;
        bit [MASK_COLS-1:0] rows [MASK_ROWS];
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        result_t            awaited_results [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            foreach (rows[r]) rows[r] = '0;
            width_reg    = MASK_WIDTH_RESET;
            height_reg   = MASK_HEIGHT_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_MASK_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int waiting();
            return awaited_results.size();
        endfunction

        function int clamp_to(int v, int hi);
            return (v < 0) ? 0 : ((v > hi) ? hi : v);
        endfunction

        // columns lo .. hi-1 set
        function bit [MASK_COLS-1:0] col_span(int lo, int hi);
            bit [MASK_COLS-1:0] one;
            one = 1;
            return ((one << hi) - 1) & ~((one << lo) - 1);
        endfunction

        function void note_request(item_t req);
            int w, h, xa, ya, xb, yb, t, r;
            bit [MASK_COLS-1:0] used, inner, sel;
            result_t res;
            res = '0;
            w  = (width_reg > MASK_COLS) ? MASK_COLS : int'(width_reg);
            h  = (height_reg > MASK_ROWS) ? MASK_ROWS : int'(height_reg);
            xa = $signed(req.x_first);
            ya = $signed(req.y_first);
            xb = $signed(req.x_second);
            yb = $signed(req.y_second);
            case (req.opcode)
                OP_READ, OP_WRITE: begin
                    if (xa < 0 || ya < 0 || xa >= w || ya >= h) begin
                        res.coord_error = 1'b1;
                    end else if (req.opcode == OP_READ) begin
                        res.permitted = rows[ya][xa];
                    end else begin
                        rows[ya][xa] = req.fill_value;
                    end
                end
                OP_CLEAR: begin
                    foreach (rows[i]) rows[i] = {MASK_COLS{req.fill_value}};
                end
                OP_FILL, OP_PROTECT, OP_INTERSECT, OP_INVERT: begin
                    // equal corners on either axis leave the mask alone
                    if (xa != xb && ya != yb) begin
                        if (xa > xb) begin
                            t = xa; xa = xb; xb = t;
                        end
                        if (ya > yb) begin
                            t = ya; ya = yb; yb = t;
                        end
                        xa = clamp_to(xa, w);
                        xb = clamp_to(xb, w);
                        ya = clamp_to(ya, h);
                        yb = clamp_to(yb, h);
                        used  = col_span(0, w);
                        inner = col_span(xa, xb);
                        for (r = 0; r < h; r++) begin
                            sel = (r >= ya && r < yb) ? inner : '0;
                            case (req.opcode)
                                OP_FILL:      rows[r] = req.fill_value ? (rows[r] & ~sel)
                                                                       : (rows[r] | sel);
                                OP_PROTECT:   rows[r] = (rows[r] & ~used) | (used & ~sel);
                                OP_INTERSECT: rows[r] = rows[r] & (~used | sel);
                                default:      rows[r] = rows[r] ^ used;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result %b with no request waiting", got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.permitted !== want.permitted)
                report_mismatch($sformatf("permitted %b, want %b", got.permitted,
                                          want.permitted));
            if (got.coord_error !== want.coord_error)
                report_mismatch($sformatf("coord_error %b, want %b", got.coord_error,
                                          want.coord_error));
        endtask
    endclass

    mask_permit_checker checker_h;

    raster_clip_mask_engine #(
        .MAX_WIDTH  (MASK_COLS),
        .MAX_HEIGHT (MASK_ROWS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: stalls at random unless a quiet stretch is running
    always @(negedge aclk) begin
        m_tready = quiet || ($urandom_range(99) >= 16);
    end

    // both handshakes are seen at the rising edge; a request is applied to
    // the bitmap copy before any result of the same edge is checked
    always @(posedge aclk) begin : monitor
        item_t req;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req.opcode     = opcode_t'(s_tuser);
                req.x_first    = s_tdata[15:0];
                req.y_first    = s_tdata[31:16];
                req.x_second   = s_tdata[47:32];
                req.y_second   = s_tdata[63:48];
                req.fill_value = s_tdata[64];
                checker_h.note_request(req);
            end
            if (m_tvalid && m_tready) checker_h.check_result(result_t'(m_tdata[1:0]));
        end
    end

    function automatic item_t make_req(opcode_t op, int xa, int ya, int xb, int yb, bit fv);
        item_t req;
        req.opcode     = op;
        req.x_first    = COORD_W'(xa);
        req.y_first    = COORD_W'(ya);
        req.x_second   = COORD_W'(xb);
        req.y_second   = COORD_W'(yb);
        req.fill_value = fv;
        return req;
    endfunction

    // mostly near the used area, sometimes any 16-bit value or an extreme
    function automatic logic signed [COORD_W-1:0] pick_coord(int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 6) return COORD_W'($urandom_range(16'hFFFF));
        if (roll < 10) return roll[0] ? 16'sh7FFF : 16'sh8000;
        return COORD_W'($urandom_range(span + 4) - 2);
    endfunction

    function automatic item_t random_request(int w, int h);
        item_t req;
        int roll;
        roll = $urandom_range(99);
        req.fill_value = 1'($urandom_range(1));
        req.x_first    = pick_coord(w);
        req.y_first    = pick_coord(h);
        req.x_second   = pick_coord(w);
        req.y_second   = pick_coord(h);
        if (roll < 51)      req.opcode = OP_READ;
        else if (roll < 69) req.opcode = OP_WRITE;
        else if (roll < 76) req.opcode = OP_FILL;
        else if (roll < 83) req.opcode = OP_PROTECT;
        else if (roll < 89) req.opcode = OP_INTERSECT;
        else if (roll < 95) req.opcode = OP_INVERT;
        else if (roll < 96) req.opcode = OP_CLEAR;     // whole-storage pass, kept rare
        else                req.opcode = OP_NOP;
        // some rectangles collapse on one axis
        if (req.opcode inside {OP_FILL, OP_PROTECT, OP_INTERSECT, OP_INVERT}
                && $urandom_range(9) == 0) begin
            if ($urandom_range(1)) req.x_second = req.x_first;
            else                   req.y_second = req.y_first;
        end
        return req;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(value);
        checker_h.set_register(idx, CFG_W'(value));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // present one request, with random idle cycles ahead of it, and hold it
    // until the block takes it
    task automatic send_request(item_t req);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 16) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, req.fill_value, req.y_second, req.x_second, req.y_first,
                    req.x_first};
        s_tuser  = req.opcode;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (checker_h.waiting() != 0) @(negedge aclk);
    endtask

    initial begin
        int eff_w, eff_h;
        checker_h = new();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed part at the reset size of 512 x 512
        send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0));           // reset state protected
        send_request(make_req(OP_WRITE, 0, 0, 0, 0, 1'b1));
        send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0));
        send_request(make_req(OP_WRITE, 511, 511, 0, 0, 1'b1));      // far corner
        send_request(make_req(OP_READ, 511, 511, 0, 0, 1'b0));
        send_request(make_req(OP_READ, -1, 5, 0, 0, 1'b0));          // pixel off the mask
        send_request(make_req(OP_READ, 512, 0, 0, 0, 1'b0));
        send_request(make_req(OP_WRITE, 0, 512, 0, 0, 1'b1));
        send_request(make_req(OP_READ, -32768, 32767, 32767, -32768, 1'b1));
        // reversed corners far outside, clamped to the whole mask
        send_request(make_req(OP_FILL, 32767, -32768, -32768, 32767, 1'b0));
        send_request(make_req(OP_READ, 300, 200, 0, 0, 1'b0));
        send_request(make_req(OP_FILL, 10, 10, 20, 20, 1'b1));
        send_request(make_req(OP_READ, 15, 15, 0, 0, 1'b0));
        send_request(make_req(OP_FILL, 5, 0, 5, 100, 1'b1));         // zero width
        send_request(make_req(OP_READ, 5, 5, 0, 0, 1'b0));
        send_request(make_req(OP_FILL, 0, 7, 100, 7, 1'b1));         // zero height
        send_request(make_req(OP_PROTECT, 100, 100, 3, 3, 1'b0));
        send_request(make_req(OP_READ, 50, 50, 0, 0, 1'b0));
        send_request(make_req(OP_INTERSECT, 0, 0, 200, 200, 1'b0));
        send_request(make_req(OP_INVERT, 1, 1, 2, 2, 1'b0));         // rectangle ignored
        send_request(make_req(OP_INVERT, 1, 1, 1, 2, 1'b0));         // zero width, no effect
        send_request(make_req(OP_READ, 400, 400, 0, 0, 1'b0));
        send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 1'b1));
        send_request(make_req(OP_READ, 511, 0, 0, 0, 1'b0));
        send_request(make_req(OP_NOP, -1, -1, 32767, 0, 1'b1));
        send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 1'b0));
        drain_results();

        // random phases, sizes only changed while nothing is in flight
        for (int p = 0; p < 12; p++) begin
            write_register(REG_MASK_WIDTH, phase_w[p]);
            write_register(REG_MASK_HEIGHT, phase_h[p]);
            eff_w = (phase_w[p] > MASK_COLS) ? MASK_COLS : phase_w[p];
            eff_h = (phase_h[p] > MASK_ROWS) ? MASK_ROWS : phase_h[p];
            // one long phase runs with no idle cycles on either side
            quiet = (p == 8);
            repeat (phase_n[p]) send_request(random_request(eff_w, eff_h));
            drain_results();
        end
        quiet = 1'b0;

        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (checker_h.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

endmodule
